// ----- hw/rtl/hba_pkg.sv -----
// ----------------------------------------------------------------------------
// hba_pkg
// Types and fixed constants shared by the heap block allocator files.
// ----------------------------------------------------------------------------
package hba_pkg;

	localparam int ALIGN_BYTES  = 16;
	localparam int HEADER_BYTES = 32;
	localparam int MIN_SPLIT    = 48;
	localparam int ADDRESS_BITS = 32;

	// Greatest heap end the address range allows
	localparam logic [33:0] ADDR_LIMIT = 34'((64'd1 << ADDRESS_BITS) - 64'd1);

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_RESIZE  = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOMEM   = 3'd1;
	localparam logic [2:0] ST_LARGE   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_NOTHING = 3'd4;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [1:0] CFG_FIT    = 2'd0;
	localparam logic [1:0] CFG_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_THRESH = 2'd2;

	localparam logic [1:0]  FIT_RESET    = FIT_FIRST;
	localparam logic [31:0] LIMIT_RESET  = 32'd1048576;
	localparam logic [31:0] THRESH_RESET = 32'd131072;

	typedef struct packed {
		logic        free;
		logic [31:0] size;
	} entry_t;

	// controller to cell chain
	typedef struct packed {
		logic   shift;
		logic   push;
		entry_t wdata;
	} chain_ctl_t;

endpackage

// ----- hw/rtl/hba_if.sv -----
// ----------------------------------------------------------------------------
// hba_if
// Request, response and register write channels of the heap block allocator.
// ----------------------------------------------------------------------------
interface hba_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] request_size;
	logic [31:0] block_address;

	modport source(output valid, kind, request_size, block_address, input ready);
	modport sink(input valid, kind, request_size, block_address, output ready);
endinterface

interface hba_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_address;
	logic [2:0]  status;
	logic        moved;
	logic [31:0] copy_length;

	modport source(output valid, result_address, status, moved, copy_length, input ready);
	modport sink(input valid, result_address, status, moved, copy_length, output ready);
endinterface

interface hba_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/hba_cell.sv -----
// ----------------------------------------------------------------------------
// hba_cell
// One table entry of the chain: loads its upper neighbour on a shift, or the
// controller's data when the write pointer names it.
// ----------------------------------------------------------------------------
module hba_cell #(
	parameter int TABLE_DEPTH = 64,
	parameter int INDEX = 0
) (
	input  logic                           clk,
	input  hba_pkg::chain_ctl_t            ctl,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wptr,
	input  hba_pkg::entry_t                up,
	output hba_pkg::entry_t                q
);
	import hba_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.push && wptr == IW'(INDEX)) begin
			entry_q <= ctl.wdata;
		end else if (ctl.shift) begin
			entry_q <= up;
		end
	end

	assign q = entry_q;

endmodule

// ----- hw/rtl/hba_ctrl.sv -----
// ----------------------------------------------------------------------------
// hba_ctrl
// Sequencer of the allocator: streams the table out of cell 0 and back into
// the chain, scanning, splitting, absorbing and merging on the way.
// ----------------------------------------------------------------------------
module hba_ctrl #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hba_req_if.sink                        req,
	hba_rsp_if.source                      rsp,
	input  logic [1:0]                     fit_strategy,
	input  logic [31:0]                    heap_limit,
	input  logic [31:0]                    large_threshold,
	input  hba_pkg::entry_t                head,
	output hba_pkg::chain_ctl_t            chain,
	output logic [$clog2(TABLE_DEPTH)-1:0] wptr
);
	import hba_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int BW = 34 + CW;

	typedef struct packed {
		logic        v;
		logic        tgt;
		logic        absb;
		logic        free;
		logic [31:0] size;
	} pend_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_EDIT   = 7'b0001000,
		S_GROW   = 7'b0010000,
		S_FREE   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [1:0]    kind_q;
	logic [31:0]   size_q;
	logic [31:0]   addr_q;
	logic [32:0]   need_q;
	logic [CW-1:0] n_q;
	logic [31:0]   heap_end_q;

	logic [CW-1:0] a_q, b_q, i_q;
	logic [BW-1:0] base_q;
	pend_t         pend_q, pend_d;

	logic          pick_v_q, exact_q;
	logic [CW-1:0] pick_q;
	logic [31:0]   pick_size_q;
	logic [BW-1:0] pick_base_q;
	logic          used_v_q, just_q, nxt_v_q, nxt_free_q;
	logic [CW-1:0] used_q;
	logic [31:0]   used_size_q, nxt_size_q;

	logic [CW-1:0] tgt_q;
	logic          absorb_q, then_free_q;
	logic [31:0]   res_q, copy_q;
	logic [2:0]    st_q;
	logic          moved_q;

	logic          rsp_v_q;
	logic [31:0]   rsp_addr_q, rsp_copy_q;
	logic [2:0]    rsp_st_q;
	logic          rsp_moved_q;

	// ---- pass engine ----
	logic          in_pass, x_av, hit_addr, at_tgt, split_ok;
	logic          pop, push, pass_done;
	entry_t        wdata;
	pend_t         y;
	logic [33:0]   sum_px;
	logic [31:0]   rem;
	logic [CW-1:0] wsum;

	assign in_pass  = state_q == S_SCAN || state_q == S_EDIT || state_q == S_FREE;
	assign x_av     = a_q != '0;
	assign hit_addr = (base_q + BW'(HEADER_BYTES)) == BW'(addr_q);
	assign at_tgt   = state_q == S_EDIT && i_q == tgt_q;
	assign sum_px   = {2'b0, pend_q.size} + 34'(HEADER_BYTES) + {2'b0, head.size};
	assign rem      = pend_q.size - need_q[31:0] - 32'(HEADER_BYTES);
	// room is counted on the live table, so an absorb frees a slot first
	assign split_ok = pend_q.v && pend_q.tgt && !pend_q.absb
		&& {2'b0, pend_q.size} >= {1'b0, need_q} + 34'(MIN_SPLIT)
		&& {2'b0, pend_q.size} >= {1'b0, need_q} + 34'(HEADER_BYTES)
		&& a_q + b_q < CW'(TABLE_DEPTH - 1);

	always_comb begin
		y.v    = 1'b1;
		y.tgt  = at_tgt;
		y.absb = at_tgt && absorb_q;
		y.size = head.size;
		if (state_q == S_FREE && hit_addr && !head.free) begin
			y.free = 1'b1;
		end else if (at_tgt) begin
			y.free = 1'b0;
		end else begin
			y.free = head.free;
		end
	end

	always_comb begin
		pend_d    = pend_q;
		pop       = 1'b0;
		push      = 1'b0;
		pass_done = 1'b0;
		wdata     = '{free: pend_q.free, size: pend_q.size};
		if (in_pass) begin
			if (pend_q.v && pend_q.absb && x_av) begin
				// grow the target over its free successor
				pend_d.size = sum_px[31:0];
				pend_d.absb = 1'b0;
				pop = 1'b1;
			end else if (split_ok) begin
				push = 1'b1;
				wdata = '{free: pend_q.free, size: need_q[31:0]};
				pend_d.size = rem;
				pend_d.free = 1'b1;
				pend_d.tgt = 1'b0;
			end else if (state_q == S_FREE && pend_q.v && pend_q.free && x_av && y.free) begin
				pend_d.size = sum_px[31:0];
				pop = 1'b1;
			end else if (x_av) begin
				push = pend_q.v;
				pend_d = y;
				pop = 1'b1;
			end else if (pend_q.v) begin
				push = 1'b1;
				pend_d.v = 1'b0;
			end else begin
				pass_done = 1'b1;
			end
		end else if (state_q == S_GROW) begin
			push = 1'b1;
			wdata = '{free: 1'b0, size: need_q[31:0]};
		end
	end

	assign wsum = a_q + b_q - {{(CW-1){1'b0}}, pop};
	assign wptr = (state_q == S_GROW) ? n_q[IW-1:0] : wsum[IW-1:0];
	assign chain.shift = pop;
	assign chain.push  = push;
	assign chain.wdata = wdata;

	// ---- scan captures ----
	logic cand, take;

	assign cand = head.free && {1'b0, head.size} >= need_q;

	always_comb begin
		case (fit_strategy)
			FIT_BEST:  take = cand && !exact_q && (!pick_v_q || head.size < pick_size_q);
			FIT_WORST: take = cand && (!pick_v_q || head.size > pick_size_q);
			default:   take = cand && !pick_v_q;
		endcase
	end

	// ---- decision ----
	logic          is_alloc, is_free, is_rsz, is_large, grow_ok, fits_here, absorb_ok;
	logic [33:0]   new_end;
	logic [31:0]   dec_res, dec_copy;
	logic [2:0]    dec_st;
	logic          dec_moved, dec_then_free, dec_absorb;
	logic [CW-1:0] dec_tgt;
	state_t        dec_next;
	logic [31:0]   pick_addr;
	logic          pass_init;

	assign is_alloc  = kind_q == KIND_ALLOC || (kind_q == KIND_RESIZE && addr_q == '0);
	assign is_free   = kind_q == KIND_FREE
		|| (kind_q == KIND_RESIZE && addr_q != '0 && size_q == '0);
	assign is_rsz    = kind_q == KIND_RESIZE && addr_q != '0 && size_q != '0;
	assign is_large  = need_q[32] || need_q[31:0] >= large_threshold;
	assign new_end   = {2'b0, heap_end_q} + 34'(HEADER_BYTES) + {1'b0, need_q};
	assign grow_ok   = n_q < CW'(TABLE_DEPTH) && new_end <= {2'b0, heap_limit}
		&& new_end <= ADDR_LIMIT;
	assign fits_here = {1'b0, used_size_q} >= need_q;
	assign absorb_ok = nxt_v_q && nxt_free_q
		&& {2'b0, used_size_q} + 34'(HEADER_BYTES) + {2'b0, nxt_size_q} >= {1'b0, need_q};
	assign pick_addr = 32'(pick_base_q + BW'(HEADER_BYTES));

	always_comb begin
		dec_res       = '0;
		dec_copy      = '0;
		dec_st        = ST_NOTHING;
		dec_moved     = 1'b0;
		dec_then_free = 1'b0;
		dec_absorb    = 1'b0;
		dec_tgt       = pick_q;
		dec_next      = S_DONE;
		if (is_alloc) begin
			if (size_q == '0) begin
				dec_st = ST_NOTHING;
			end else if (is_large) begin
				dec_st = ST_LARGE;
			end else if (pick_v_q) begin
				dec_st = ST_OK;
				dec_res = pick_addr;
				dec_next = S_EDIT;
			end else if (grow_ok) begin
				dec_st = ST_OK;
				dec_res = heap_end_q + 32'(HEADER_BYTES);
				dec_next = S_GROW;
			end else begin
				dec_st = ST_NOMEM;
			end
		end else if (is_free) begin
			if (addr_q == '0) begin
				dec_st = ST_NOTHING;
			end else if (!used_v_q) begin
				dec_st = ST_UNKNOWN;
			end else begin
				dec_st = ST_OK;
				dec_next = S_FREE;
			end
		end else if (is_rsz) begin
			if (!used_v_q) begin
				dec_st = ST_UNKNOWN;
			end else if (fits_here || absorb_ok) begin
				dec_st = ST_OK;
				dec_res = addr_q;
				dec_tgt = used_q;
				dec_absorb = !fits_here;
				dec_next = S_EDIT;
			end else if (is_large) begin
				dec_st = ST_LARGE;
			end else if (pick_v_q || grow_ok) begin
				// move: place the new block, then release the old one
				dec_st = ST_OK;
				dec_moved = 1'b1;
				dec_copy = used_size_q;
				dec_then_free = 1'b1;
				dec_res = pick_v_q ? pick_addr : heap_end_q + 32'(HEADER_BYTES);
				dec_next = pick_v_q ? S_EDIT : S_GROW;
			end else begin
				dec_st = ST_NOMEM;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (req.valid) state_d = S_SCAN;
			S_SCAN:   if (pass_done) state_d = S_DECIDE;
			S_DECIDE: state_d = dec_next;
			S_EDIT:   if (pass_done) state_d = then_free_q ? S_FREE : S_DONE;
			S_GROW:   state_d = then_free_q ? S_FREE : S_DONE;
			S_FREE:   if (pass_done) state_d = S_DONE;
			S_DONE:   if (!rsp_v_q || rsp.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	assign pass_init = state_d != state_q
		&& (state_d == S_SCAN || state_d == S_EDIT || state_d == S_FREE);

	assign req.ready = state_q == S_IDLE;

	logic [32:0] req_pad;
	assign req_pad = {1'b0, req.request_size} + 33'(ALIGN_BYTES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			heap_end_q  <= '0;
			a_q         <= '0;
			b_q         <= '0;
			i_q         <= '0;
			base_q      <= '0;
			pend_q      <= '0;
			pick_v_q    <= 1'b0;
			exact_q     <= 1'b0;
			used_v_q    <= 1'b0;
			just_q      <= 1'b0;
			nxt_v_q     <= 1'b0;
			then_free_q <= 1'b0;
			absorb_q    <= 1'b0;
			rsp_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == S_IDLE && req.valid) begin
				kind_q <= req.kind;
				size_q <= req.request_size;
				addr_q <= req.block_address;
				need_q <= req_pad - (req_pad % 33'(ALIGN_BYTES));
			end

			if (pass_init) begin
				// the count left by an edit pass or a growth is not in n_q yet
				if (state_q == S_GROW)
					a_q <= n_q + 1'b1;
				else if (in_pass)
					a_q <= b_q;
				else
					a_q <= n_q;
				b_q    <= '0;
				i_q    <= '0;
				base_q <= '0;
				pend_q <= '0;
			end else begin
				pend_q <= pend_d;
				if (pop) begin
					a_q    <= a_q - 1'b1;
					i_q    <= i_q + 1'b1;
					base_q <= base_q + BW'(HEADER_BYTES) + BW'(head.size);
				end
				if (push) b_q <= b_q + 1'b1;
			end

			if (in_pass && pass_done) n_q <= b_q;

			if (state_q == S_GROW) begin
				n_q        <= n_q + 1'b1;
				heap_end_q <= new_end[31:0];
			end

			if (pass_init && state_d == S_SCAN) begin
				pick_v_q <= 1'b0;
				exact_q  <= 1'b0;
				used_v_q <= 1'b0;
				just_q   <= 1'b0;
				nxt_v_q  <= 1'b0;
			end else if (state_q == S_SCAN && pop) begin
				if (take) begin
					pick_v_q    <= 1'b1;
					pick_q      <= i_q;
					pick_size_q <= head.size;
					pick_base_q <= base_q;
					if (fit_strategy == FIT_BEST && {1'b0, head.size} == need_q)
						exact_q <= 1'b1;
				end
				just_q <= !used_v_q && hit_addr && !head.free;
				if (!used_v_q && hit_addr && !head.free) begin
					used_v_q    <= 1'b1;
					used_q      <= i_q;
					used_size_q <= head.size;
				end
				if (just_q) begin
					nxt_v_q    <= 1'b1;
					nxt_free_q <= head.free;
					nxt_size_q <= head.size;
				end
			end

			if (state_q == S_DECIDE) begin
				res_q       <= dec_res;
				st_q        <= dec_st;
				moved_q     <= dec_moved;
				copy_q      <= dec_copy;
				then_free_q <= dec_then_free;
				absorb_q    <= dec_absorb;
				tgt_q       <= dec_tgt;
			end

			if (state_q == S_DONE && (!rsp_v_q || rsp.ready)) begin
				rsp_v_q     <= 1'b1;
				rsp_addr_q  <= res_q;
				rsp_st_q    <= st_q;
				rsp_moved_q <= moved_q;
				rsp_copy_q  <= copy_q;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = rsp_v_q;
	assign rsp.result_address = rsp_addr_q;
	assign rsp.status         = rsp_st_q;
	assign rsp.moved          = rsp_moved_q;
	assign rsp.copy_length    = rsp_copy_q;

endmodule

// ----- hw/rtl/heap_block_allocator.sv -----
// ----------------------------------------------------------------------------
// heap_block_allocator
// Heap block manager over an address-ordered table held in a chain of cells.
//
// Channels: req carries kind, request_size and block_address; rsp returns
// result_address, status, moved and copy_length, one transfer per request;
// cfg writes fit_strategy (0), heap_limit (1) and large_threshold (2) and is
// always ready. Registers are to be written only while no request is in
// flight; the block itself does not enforce this. One request at a time.
// An answer found by the scan alone needs a scan pass; an allocate, free or
// in-place resize adds an edit pass, a growth step or a merge pass, and a
// resize that moves adds a merge pass after its edit pass or growth. Each
// pass turns the table out of cell 0 and through the sequencer back into
// the chain, one entry at a time.
// req is ready in the idle state, also while a result waits in the output
// register; a stalled rsp holds its transfer and the next result waits.
// Reset empties the table and heap at once and restores the register
// defaults; table entries are only read below the block count.
// ----------------------------------------------------------------------------
module heap_block_allocator #(
	parameter int TABLE_DEPTH = 64
) (
	input logic       clk,
	input logic       arst_n,
	hba_req_if.sink   req,
	hba_rsp_if.source rsp,
	hba_cfg_if.sink   cfg
);
	import hba_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);

	logic [1:0]  fit_q;
	logic [31:0] limit_q;
	logic [31:0] thresh_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q    <= FIT_RESET;
			limit_q  <= LIMIT_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FIT:    fit_q <= cfg.data[1:0];
				CFG_LIMIT:  limit_q <= cfg.data;
				CFG_THRESH: thresh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	chain_ctl_t      chain;
	logic [IW-1:0]   wptr;
	entry_t          cell_q [TABLE_DEPTH];
	entry_t          up_w   [TABLE_DEPTH];

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		if (k == TABLE_DEPTH - 1) begin : g_top
			assign up_w[k] = '0;
		end else begin : g_mid
			assign up_w[k] = cell_q[k+1];
		end

		hba_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.INDEX(k)
		) u_cell (
			.clk  (clk),
			.ctl  (chain),
			.wptr (wptr),
			.up   (up_w[k]),
			.q    (cell_q[k])
		);
	end

	hba_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.fit_strategy    (fit_q),
		.heap_limit      (limit_q),
		.large_threshold (thresh_q),
		.head            (cell_q[0]),
		.chain           (chain),
		.wptr            (wptr)
	);

endmodule
